@@ sv/arpag_pkg.sv @@
// ----------------------------------------------------------------------------
// arpag_pkg
// Shared widths, codes and status types for the ring peak gain control block.
// ----------------------------------------------------------------------------
package arpag_pkg;

   // ring geometry; both depths are powers of two
   localparam int RING_DEPTH    = 2048;
   localparam int WINDOW_LENGTH = 512;
   localparam int RING_AW       = $clog2(RING_DEPTH);

   localparam int SAMPLE_W = 16;
   localparam int GAIN_W   = 15;
   localparam int INDEX_W  = 9;
   localparam int TIME_W   = 32;
   localparam int KIND_W   = 2;

   // serial multiplier operand width and product width
   localparam int MUL_W  = 16;
   localparam int MPROD_W = 2 * MUL_W;
   // dividend of the scaling divide: gain times sample magnitude
   localparam int PROD_W = GAIN_W + SAMPLE_W;

   localparam int MUL_CW = $clog2(MUL_W + 1);
   localparam int DIV_CW = $clog2(PROD_W + 1);

   // item kinds
   localparam logic [KIND_W-1:0] KIND_CAPTURE = 2'd0;
   localparam logic [KIND_W-1:0] KIND_READ    = 2'd1;
   localparam logic [KIND_W-1:0] KIND_IDLE    = 2'd2;

   // register indexes
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 16;
   localparam logic [CSR_IDX_W-1:0] CSR_CAPTURE_EN   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_TARGET  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DECAY_FACTOR = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_DECAY_PERIOD = 2'd3;

   // reset values
   localparam logic [GAIN_W-1:0]   GAIN_TARGET_RST  = 15'd31000;
   localparam logic [MUL_W-1:0]    DECAY_FACTOR_RST = 16'd62259;
   localparam logic [MUL_W-1:0]    DECAY_PERIOD_RST = 16'd1000;

   typedef struct packed {
      logic busy;
      logic done;
   } serial_stat_type;

endpackage

@@ sv/arpag_mul.sv @@
// ----------------------------------------------------------------------------
// arpag_mul
// Bit-serial shift-add multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module arpag_mul
   import arpag_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [MUL_W-1:0]     a,
   input  logic [MUL_W-1:0]     b,
   output logic [MPROD_W-1:0]   prod,
   output serial_stat_type      stat
);

   logic [MUL_W-1:0]   a_ff;
   logic [MPROD_W-1:0] prod_ff, prod_in;
   logic [MUL_CW-1:0]  count_ff, count_in;
   logic               done_ff, done_in;
   logic [MUL_W:0]     sum;

   // upper half accumulates, low half shifts the multiplier out
   assign sum = {1'b0, prod_ff[MPROD_W-1:MUL_W]} + {1'b0, (prod_ff[0] ? a_ff : '0)};

   always_comb begin
      prod_in  = prod_ff;
      count_in = count_ff;
      done_in  = 1'b0;
      if (start) begin
         prod_in  = {{MUL_W{1'b0}}, b};
         count_in = MUL_CW'(MUL_W);
      end else if (count_ff != '0) begin
         prod_in  = {sum, prod_ff[MUL_W-1:1]};
         count_in = count_ff - 1'b1;
         done_in  = (count_ff == MUL_CW'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         done_ff  <= 1'b0;
      end else begin
         count_ff <= count_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      if (start) begin
         a_ff <= a;
      end
   end

   assign prod      = prod_ff;
   assign stat.busy = (count_ff != '0);
   assign stat.done = done_ff;

endmodule

@@ sv/arpag_div.sv @@
// ----------------------------------------------------------------------------
// arpag_div
// Bit-serial restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module arpag_div
   import arpag_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [PROD_W-1:0]    dividend,
   input  logic [MUL_W-1:0]     divisor,
   output logic [PROD_W-1:0]    quotient,
   output serial_stat_type      stat
);

   logic [MUL_W-1:0]  den_ff;
   logic [MUL_W-1:0]  rem_ff, rem_in;
   logic [PROD_W-1:0] quo_ff, quo_in;
   logic [DIV_CW-1:0] count_ff, count_in;
   logic              done_ff, done_in;
   logic [MUL_W:0]    trial;
   logic [MUL_W+1:0]  diff;
   logic              fits;

   // remainder stays below the divisor, so 16 bits hold it
   assign trial = {rem_ff, quo_ff[PROD_W-1]};
   assign diff  = {1'b0, trial} - {2'b0, den_ff};
   assign fits  = ~diff[MUL_W+1];

   always_comb begin
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      count_in = count_ff;
      done_in  = 1'b0;
      if (start) begin
         rem_in   = '0;
         quo_in   = dividend;
         count_in = DIV_CW'(PROD_W);
      end else if (count_ff != '0) begin
         rem_in   = fits ? diff[MUL_W-1:0] : trial[MUL_W-1:0];
         quo_in   = {quo_ff[PROD_W-2:0], fits};
         count_in = count_ff - 1'b1;
         done_in  = (count_ff == DIV_CW'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         done_ff  <= 1'b0;
      end else begin
         count_ff <= count_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      if (start) begin
         den_ff <= divisor;
      end
   end

   assign quotient  = quo_ff;
   assign stat.busy = (count_ff != '0);
   assign stat.done = done_ff;

endmodule

@@ sv/audio_ring_peak_auto_gain_top.sv @@
// ----------------------------------------------------------------------------
// audio_ring_peak_auto_gain_top
// Sample ring with peak-tracking automatic gain control and serial arithmetic.
// ----------------------------------------------------------------------------
// A capture beat stores its sample in the 2048-entry ring. With capture
// enabled, a read beat passes through the registered ring read, the
// bit-serial multiply by gain_target, the bit-serial divide by the running
// maximum and then the result register. An idle beat runs the 16-step serial
// multiply used for the decay. The block works on one beat at a time; a
// finished result waits in the output register while the next beat is taken.
// Unwritten ring entries read as zero through a saturating fill count, so no
// clearing pass follows reset. Configuration writes are always taken.
module audio_ring_peak_auto_gain_top
   import arpag_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,

   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [KIND_W-1:0]          req_kind,
   input  logic signed [SAMPLE_W-1:0] req_sample,
   input  logic [INDEX_W-1:0]         req_window_index,
   input  logic [TIME_W-1:0]          req_now_ms,

   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic signed [SAMPLE_W-1:0] rsp_result_sample,
   output logic [SAMPLE_W-1:0]        rsp_level,

   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [CSR_IDX_W-1:0]       csr_index,
   input  logic [CSR_DATA_W-1:0]      csr_data
);

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_RD_MEM = 6'b000010,
      ST_MUL    = 6'b000100,
      ST_DIV    = 6'b001000,
      ST_UPD    = 6'b010000,
      ST_OUT    = 6'b100000
   } state_type;

   localparam logic [RING_AW-1:0] WIN_OFF = RING_AW'(WINDOW_LENGTH % RING_DEPTH);

   state_type state_ff, state_in;

   // configuration
   logic                capture_en_ff;
   logic [GAIN_W-1:0]   gain_target_ff;
   logic [MUL_W-1:0]    decay_factor_ff;
   logic [MUL_W-1:0]    decay_period_ff;

   // gain state
   logic [RING_AW-1:0]  write_index_ff;
   logic [RING_AW:0]    fill_ff;
   logic [SAMPLE_W-1:0] running_max_ff, all_time_max_ff, window_peak_ff;
   logic [TIME_W-1:0]   last_decay_ff;

   // per-beat working registers
   logic                op_read_ff;
   logic [TIME_W-1:0]   now_ff;
   logic                neg_ff;
   logic [SAMPLE_W-1:0] res_sample_ff, res_level_ff;

   // ring
   logic [SAMPLE_W-1:0] ring_mem [RING_DEPTH];
   logic [SAMPLE_W-1:0] rd_q_ff;
   logic                rd_ok_ff;
   logic [RING_AW-1:0]  rd_addr;

   // output register
   logic                rsp_valid_ff;
   logic [SAMPLE_W-1:0] rsp_sample_ff, rsp_level_ff;

   logic                req_take, wr_en, rd_en, out_free;
   logic                mul_start, div_start;
   logic [MUL_W-1:0]    mul_a, mul_b;
   logic [MPROD_W-1:0]  mul_prod;
   logic [PROD_W-1:0]   div_quo;
   serial_stat_type     mul_stat, div_stat;

   logic [SAMPLE_W-1:0] rd_val, rd_mag, divisor;
   logic [TIME_W-1:0]   elapsed;
   logic                peak_wins, decay_go;
   logic [SAMPLE_W-1:0] rm1, atm1, half_atm, rm2;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid & ~req_stall;
   assign wr_en     = req_take & (req_kind == KIND_CAPTURE);
   assign rd_en     = req_take & (req_kind == KIND_READ) & capture_en_ff;
   assign out_free  = ~rsp_valid_ff | ~rsp_stall;
   assign csr_ready = 1'b1;

   // newest window ends just before the write pointer
   assign rd_addr = write_index_ff - WIN_OFF
                    + RING_AW'(req_window_index % WINDOW_LENGTH);

   always_ff @(posedge clock) begin
      if (wr_en) begin
         ring_mem[write_index_ff] <= req_sample;
      end
      if (rd_en) begin
         rd_q_ff  <= ring_mem[rd_addr];
         rd_ok_ff <= ({1'b0, rd_addr} < fill_ff);
      end
   end

   assign rd_val = rd_ok_ff ? rd_q_ff : '0;
   assign rd_mag = rd_val[SAMPLE_W-1] ? (~rd_val + 1'b1) : rd_val;
   assign divisor = (running_max_ff == '0) ? SAMPLE_W'(1) : running_max_ff;

   always_comb begin
      mul_start = 1'b0;
      mul_a     = running_max_ff;
      mul_b     = decay_factor_ff;
      if (state_ff == ST_RD_MEM) begin
         mul_start = 1'b1;
         mul_a     = rd_mag;
         mul_b     = {1'b0, gain_target_ff};
      end else if (req_take && req_kind == KIND_IDLE) begin
         mul_start = 1'b1;
      end
   end

   assign div_start = (state_ff == ST_MUL) & mul_stat.done & op_read_ff;

   arpag_mul u_mul (
      .clock (clock),
      .reset (reset),
      .start (mul_start),
      .a     (mul_a),
      .b     (mul_b),
      .prod  (mul_prod),
      .stat  (mul_stat)
   );

   arpag_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (mul_prod[PROD_W-1:0]),
      .divisor  (divisor),
      .quotient (div_quo),
      .stat     (div_stat)
   );

   // idle update: peak, else decay, then all-time max and half clamp
   assign elapsed   = now_ff - last_decay_ff;
   assign peak_wins = window_peak_ff > running_max_ff;
   assign decay_go  = ~peak_wins & (elapsed > {16'b0, decay_period_ff});
   assign rm1       = peak_wins ? window_peak_ff :
                      (decay_go ? mul_prod[MPROD_W-1:MUL_W] : running_max_ff);
   assign atm1      = (rm1 > all_time_max_ff) ? rm1 : all_time_max_ff;
   assign half_atm  = {1'b0, atm1[SAMPLE_W-1:1]};
   assign rm2       = (rm1 > half_atm) ? half_atm : rm1;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               if (req_kind == KIND_READ) begin
                  state_in = capture_en_ff ? ST_RD_MEM : ST_OUT;
               end else if (req_kind == KIND_IDLE) begin
                  state_in = ST_MUL;
               end
            end
         end
         ST_RD_MEM: state_in = ST_MUL;
         ST_MUL: begin
            if (mul_stat.done) begin
               state_in = op_read_ff ? ST_DIV : ST_UPD;
            end
         end
         ST_DIV: begin
            if (div_stat.done) begin
               state_in = ST_OUT;
            end
         end
         ST_UPD: state_in = ST_OUT;
         ST_OUT: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         capture_en_ff   <= 1'b1;
         gain_target_ff  <= GAIN_TARGET_RST;
         decay_factor_ff <= DECAY_FACTOR_RST;
         decay_period_ff <= DECAY_PERIOD_RST;
         write_index_ff  <= '0;
         fill_ff         <= '0;
         running_max_ff  <= '0;
         all_time_max_ff <= '0;
         window_peak_ff  <= '0;
         last_decay_ff   <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;

         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               CSR_CAPTURE_EN:   capture_en_ff   <= csr_data[0];
               CSR_GAIN_TARGET:  gain_target_ff  <= csr_data[GAIN_W-1:0];
               CSR_DECAY_FACTOR: decay_factor_ff <= csr_data;
               CSR_DECAY_PERIOD: decay_period_ff <= csr_data;
               default: ;
            endcase
         end

         if (wr_en) begin
            write_index_ff <= write_index_ff + 1'b1;
            if (fill_ff != (RING_AW+1)'(RING_DEPTH)) begin
               fill_ff <= fill_ff + 1'b1;
            end
         end

         if (state_ff == ST_RD_MEM && rd_mag > window_peak_ff) begin
            window_peak_ff <= rd_mag;
         end

         if (state_ff == ST_UPD) begin
            running_max_ff  <= rm2;
            all_time_max_ff <= atm1;
            window_peak_ff  <= '0;
            if (decay_go) begin
               last_decay_ff <= now_ff;
            end
         end

         if (state_ff == ST_OUT && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         op_read_ff <= (req_kind == KIND_READ);
         now_ff     <= req_now_ms;
         if (req_kind == KIND_READ && !capture_en_ff) begin
            res_sample_ff <= '0;
            res_level_ff  <= running_max_ff;
         end
      end
      if (state_ff == ST_RD_MEM) begin
         neg_ff <= rd_val[SAMPLE_W-1];
      end
      if (state_ff == ST_DIV && div_stat.done) begin
         // truncation toward zero, low 16 bits kept
         res_sample_ff <= neg_ff ? (~div_quo[SAMPLE_W-1:0] + 1'b1) : div_quo[SAMPLE_W-1:0];
         res_level_ff  <= running_max_ff;
      end
      if (state_ff == ST_UPD) begin
         res_sample_ff <= '0;
         res_level_ff  <= rm2;
      end
      if (state_ff == ST_OUT && out_free) begin
         rsp_sample_ff <= res_sample_ff;
         rsp_level_ff  <= res_level_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_result_sample = rsp_sample_ff;
   assign rsp_level         = rsp_level_ff;

`ifndef SYNTH
   // idle updates always leave the level within half the all-time maximum
   assert property (@(posedge clock) disable iff (reset)
      running_max_ff <= {1'b0, all_time_max_ff[SAMPLE_W-1:1]})
      else $error("running max above half of all-time max");

   assert property (@(posedge clock) disable iff (reset)
      mul_stat.done |-> (state_ff == ST_MUL))
      else $error("multiplier finished outside multiply state");

   assert property (@(posedge clock) disable iff (reset)
      div_stat.done |-> (state_ff == ST_DIV))
      else $error("divider finished outside divide state");

   assert property (@(posedge clock) disable iff (reset)
      fill_ff <= (RING_AW+1)'(RING_DEPTH))
      else $error("fill count beyond ring depth");
`endif

endmodule

@@ bench/tb_audio_ring_peak_auto_gain_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_audio_ring_peak_auto_gain_top
// Self-checking bench for the ring peak automatic gain control block.
// ----------------------------------------------------------------------------
// A queue of beats (captures, window reads, gain updates and the odd unused
// kind) feeds a clocked driver; a clocked monitor checks every result beat
// against a behavioural gain model updated on each accepted request beat.
// Phases run with different register settings and idle patterns on both
// channels; registers are only written once the block has drained.
// ----------------------------------------------------------------------------
module tb_audio_ring_peak_auto_gain_top;
   import arpag_pkg::*;

   localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

   localparam int N_PHASES         = 9;
   localparam int BEATS_PER_PHASE  = 112;
   localparam int SETTLE_CYCLES    = 100;
   localparam int WATCHDOG_CYCLES  = 5000;

   typedef struct {
      logic [KIND_W-1:0]          kind;
      logic signed [SAMPLE_W-1:0] sample;
      logic [INDEX_W-1:0]         window_index;
      logic [TIME_W-1:0]          now_ms;
   } gain_beat_type;

   typedef struct {
      logic signed [SAMPLE_W-1:0] result_sample;
      logic [SAMPLE_W-1:0]        level;
   } gain_rsp_type;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;

   logic                       req_valid = 1'b0;
   logic                       req_stall;
   logic [KIND_W-1:0]          req_kind = '0;
   logic signed [SAMPLE_W-1:0] req_sample = '0;
   logic [INDEX_W-1:0]         req_window_index = '0;
   logic [TIME_W-1:0]          req_now_ms = '0;

   logic                       rsp_valid;
   logic                       rsp_stall = 1'b0;
   logic signed [SAMPLE_W-1:0] rsp_result_sample;
   logic [SAMPLE_W-1:0]        rsp_level;

   logic                       csr_valid = 1'b0;
   logic                       csr_ready;
   logic [CSR_IDX_W-1:0]       csr_index = '0;
   logic [CSR_DATA_W-1:0]      csr_data = '0;

   audio_ring_peak_auto_gain_top u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_kind          (req_kind),
      .req_sample        (req_sample),
      .req_window_index  (req_window_index),
      .req_now_ms        (req_now_ms),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_result_sample (rsp_result_sample),
      .rsp_level         (rsp_level),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   always #5ns clock = ~clock;

   // gain model state and register mirror
   logic signed [SAMPLE_W-1:0] ring_mirror [RING_DEPTH];
   logic [RING_AW-1:0]         wr_ptr;
   int unsigned                run_max, peak_max, win_peak;
   logic [TIME_W-1:0]          last_decay_ms;
   logic                       cfg_capture_en;
   logic [GAIN_W-1:0]          cfg_gain;
   logic [MUL_W-1:0]           cfg_decay_factor;
   logic [MUL_W-1:0]           cfg_decay_period;

   gain_beat_type  beat_q [$];
   gain_rsp_type   gain_rsp_q [$];
   gain_beat_type  cur_beat;

   int unsigned send_gap_pct = 22;
   int unsigned rsp_hold_pct = 59;
   logic [TIME_W-1:0] stim_now_ms;

   int n_capture, n_read, n_idle, n_unused, n_checked, n_mismatch, n_writes;
   int quiet_cycles;

   task automatic report_mismatch(input string msg);
      $display("%0t ns  MISMATCH  %s", $time, msg);
      n_mismatch++;
   endtask

   // advance the model by one accepted beat and queue what it should return
   function automatic void apply_gain_beat(input gain_beat_type b);
      gain_rsp_type       r;
      logic [RING_AW-1:0] pos;
      int                 v;
      int unsigned        mag;
      longint             den, q;
      longint unsigned    decayed;
      logic [TIME_W-1:0]  elapsed;
      r.result_sample = '0;
      r.level         = '0;
      case (b.kind)
         KIND_CAPTURE: begin
            ring_mirror[wr_ptr] = b.sample;
            wr_ptr = wr_ptr + 1'b1;
            n_capture++;
         end
         KIND_READ: begin
            if (cfg_capture_en) begin
               pos = wr_ptr - RING_AW'(WINDOW_LENGTH)
                     + RING_AW'(b.window_index % WINDOW_LENGTH);
               v   = int'(ring_mirror[pos]);
               mag = (v < 0) ? -v : v;
               if (mag > win_peak)
                  win_peak = mag;
               den = (run_max == 0) ? 64'sd1 : longint'(run_max);
               q   = (longint'(cfg_gain) * longint'(v)) / den;
               r.result_sample = q[SAMPLE_W-1:0];
            end
            r.level = run_max[SAMPLE_W-1:0];
            gain_rsp_q.push_back(r);
            n_read++;
         end
         KIND_IDLE: begin
            if (win_peak > run_max) begin
               run_max = win_peak;
            end else begin
               elapsed = b.now_ms - last_decay_ms;
               if (elapsed > TIME_W'(cfg_decay_period)) begin
                  last_decay_ms = b.now_ms;
                  decayed = (longint'(run_max) * longint'(cfg_decay_factor)) >> 16;
                  run_max = decayed[31:0];
               end
            end
            if (run_max > peak_max)
               peak_max = run_max;
            if (run_max > peak_max / 2)
               run_max = peak_max / 2;
            win_peak = 0;
            r.level = run_max[SAMPLE_W-1:0];
            gain_rsp_q.push_back(r);
            n_idle++;
         end
         default: n_unused++;
      endcase
   endfunction

   task automatic check_gain_result(input logic signed [SAMPLE_W-1:0] got_sample,
                                    input logic [SAMPLE_W-1:0] got_level);
      gain_rsp_type want;
      if (gain_rsp_q.size() == 0) begin
         report_mismatch($sformatf("result beat with nothing outstanding (sample %0d level %0d)",
                                   got_sample, got_level));
      end else begin
         want = gain_rsp_q.pop_front();
         n_checked++;
         if (got_sample !== want.result_sample)
            report_mismatch($sformatf("result_sample got %0d want %0d",
                                      got_sample, want.result_sample));
         if (got_level !== want.level)
            report_mismatch($sformatf("level got %0d want %0d", got_level, want.level));
      end
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall)
            apply_gain_beat(cur_beat);
         if (!req_valid || !req_stall) begin
            if (beat_q.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
               cur_beat = beat_q.pop_front();
               req_valid        <= 1'b1;
               req_kind         <= cur_beat.kind;
               req_sample       <= cur_beat.sample;
               req_window_index <= cur_beat.window_index;
               req_now_ms       <= cur_beat.now_ms;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // result monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall)
            check_gain_result(rsp_result_sample, rsp_level);
         rsp_stall <= ($urandom_range(99) < rsp_hold_pct);
      end
   end

   // watchdog: any handshake on any channel counts as progress
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)
          || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_CYCLES) begin
         $display("Watchdog: no beat accepted for %0d cycles, %0d results outstanding",
                  quiet_cycles, gain_rsp_q.size());
         $display("Regression FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         CSR_CAPTURE_EN:   cfg_capture_en   = data[0];
         CSR_GAIN_TARGET:  cfg_gain         = data[GAIN_W-1:0];
         CSR_DECAY_FACTOR: cfg_decay_factor = data;
         CSR_DECAY_PERIOD: cfg_decay_period = data;
         default: ;
      endcase
      n_writes++;
   endtask

   task automatic configure_phase(input int phase);
      logic                  en;
      logic [GAIN_W-1:0]     gain;
      logic [MUL_W-1:0]      factor, period;
      case (phase)
         1: begin
            en = 1'b1; gain = '1; factor = '1; period = 16'd1;
         end
         2: begin
            // disabled reads, zero gain, full decay, zero period
            en = 1'b0; gain = '0; factor = '0; period = '0;
         end
         default: begin
            en     = ($urandom_range(3) != 0);
            gain   = GAIN_W'($urandom_range(32767));
            factor = ($urandom_range(1) != 0) ? MUL_W'($urandom_range(40000, 65535))
                                              : MUL_W'($urandom_range(65535));
            period = ($urandom_range(1) != 0) ? MUL_W'($urandom_range(1, 3000))
                                              : MUL_W'($urandom_range(1, 65535));
         end
      endcase
      write_reg(CSR_CAPTURE_EN,   CSR_DATA_W'(en));
      write_reg(CSR_GAIN_TARGET,  CSR_DATA_W'(gain));
      write_reg(CSR_DECAY_FACTOR, factor);
      write_reg(CSR_DECAY_PERIOD, period);
   endtask

   function automatic void push_beat(input logic [KIND_W-1:0] kind,
                                     input logic signed [SAMPLE_W-1:0] sample,
                                     input logic [INDEX_W-1:0] widx,
                                     input logic [TIME_W-1:0] now);
      gain_beat_type b;
      b.kind = kind; b.sample = sample; b.window_index = widx; b.now_ms = now;
      beat_q.push_back(b);
   endfunction

   function automatic logic signed [SAMPLE_W-1:0] pick_sample();
      logic [SAMPLE_W-1:0] s;
      case ($urandom_range(7))
         0: s = 16'h7fff;
         1: s = 16'h8000;
         2: s = SAMPLE_W'($urandom_range(63)) - 16'd32;
         default: s = SAMPLE_W'($urandom());
      endcase
      return s;
   endfunction

   function automatic logic [TIME_W-1:0] next_now();
      if ($urandom_range(9) == 0)
         stim_now_ms = stim_now_ms + $urandom();
      else
         stim_now_ms = stim_now_ms + $urandom_range(3 * cfg_decay_period + 2);
      return stim_now_ms;
   endfunction

   // one beat of the given kind, unused fields random
   function automatic void push_random(input logic [KIND_W-1:0] kind);
      logic [TIME_W-1:0] now;
      now = (kind == KIND_IDLE) ? next_now() : $urandom();
      push_beat(kind, (kind == KIND_CAPTURE) ? pick_sample() : SAMPLE_W'($urandom()),
                INDEX_W'($urandom_range(WINDOW_LENGTH - 1)), now);
   endfunction

   task automatic queue_directed_beats();
      push_beat(KIND_READ,    16'sd0, 9'd0, 32'd0);        // empty ring
      push_beat(KIND_CAPTURE, 16'sh7fff, 9'd0, 32'd0);
      push_beat(KIND_CAPTURE, 16'sh8000, 9'h1ff, 32'hffff_ffff);
      push_beat(KIND_CAPTURE, 16'sd0, 9'd0, 32'd0);
      push_beat(KIND_CAPTURE, 16'sd1, 9'd0, 32'd0);
      push_beat(KIND_CAPTURE, -16'sd1, 9'd0, 32'd0);
      // newest samples at the top of the window; running max still zero
      push_beat(KIND_READ,    16'sd0, 9'd507, 32'd0);
      push_beat(KIND_READ,    16'sd0, 9'd508, 32'd0);
      push_beat(KIND_READ,    16'sd0, 9'd511, 32'd0);
      push_beat(KIND_READ,    16'sd0, 9'd0, 32'd0);        // wraps to ring end
      push_beat(KIND_UNUSED,  16'sh7fff, 9'h1ff, 32'hffff_ffff);
      push_beat(KIND_IDLE,    16'sd0, 9'd0, 32'd500);      // peak taken, clamped
      push_beat(KIND_READ,    16'sd0, 9'd507, 32'd0);
      push_beat(KIND_READ,    16'sd0, 9'd508, 32'd0);
      push_beat(KIND_IDLE,    16'sd0, 9'd0, 32'd600);
      push_beat(KIND_IDLE,    16'sd0, 9'd0, 32'd1000);     // period not exceeded
      push_beat(KIND_IDLE,    16'sd0, 9'd0, 32'd1001);     // decays
      push_beat(KIND_IDLE,    16'sd0, 9'd0, 32'hffff_fff0);
      push_beat(KIND_IDLE,    16'sd0, 9'd0, 32'd5);        // elapsed wraps, small
      push_beat(KIND_READ,    16'sd0, 9'd509, 32'd0);
      stim_now_ms = 32'd5;
   endtask

   // mostly capture bursts followed by window reads and a gain update,
   // with some mixed-kind noise
   task automatic queue_random_beats(input int target);
      int counted, burst, i;
      logic [KIND_W-1:0] k;
      counted = 0;
      while (counted < target) begin
         if ($urandom_range(7) == 0) begin
            for (i = 0; i < 5; i++) begin
               k = KIND_W'($urandom_range(3));
               push_random(k);
               if (k != KIND_UNUSED)
                  counted++;
            end
         end
         burst = ($urandom_range(9) == 0) ? $urandom_range(60, 160) : $urandom_range(40);
         for (i = 0; i < burst; i++)
            push_random(KIND_CAPTURE);
         counted += burst;
         burst = $urandom_range(1, 6);
         for (i = 0; i < burst; i++)
            push_random(KIND_READ);
         counted += burst;
         if ($urandom_range(4) != 0) begin
            push_random(KIND_IDLE);
            counted++;
         end
         if ($urandom_range(15) == 0)
            push_random(KIND_UNUSED);
      end
   endtask

   // wait for the queue and all results, then let any capture still in flight finish
   task automatic drain();
      @(negedge clock);
      while (beat_q.size() != 0 || req_valid || gain_rsp_q.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   initial begin
      int phase;
      foreach (ring_mirror[i])
         ring_mirror[i] = '0;
      wr_ptr           = '0;
      run_max          = 0;
      peak_max         = 0;
      win_peak         = 0;
      last_decay_ms    = '0;
      cfg_capture_en   = 1'b1;
      cfg_gain         = GAIN_TARGET_RST;
      cfg_decay_factor = DECAY_FACTOR_RST;
      cfg_decay_period = DECAY_PERIOD_RST;
      stim_now_ms      = '0;

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      for (phase = 0; phase < N_PHASES; phase++) begin
         @(negedge clock);
         case (phase * 3 / N_PHASES)
            0: begin send_gap_pct = 22; rsp_hold_pct = 59; end
            1: begin send_gap_pct = 59; rsp_hold_pct = 22; end
            default: begin send_gap_pct = 0; rsp_hold_pct = 0; end
         endcase
         if (phase > 0)
            configure_phase(phase);
         @(negedge clock);
         if (phase == 0)
            queue_directed_beats();
         queue_random_beats(BEATS_PER_PHASE);
         drain();
      end

      $display("Covered %0d captures, %0d window reads, %0d gain updates, %0d unused beats",
               n_capture, n_read, n_idle, n_unused);
      $display("over %0d phases with %0d register writes; %0d results checked, %0d mismatches",
               N_PHASES, n_writes, n_checked, n_mismatch);
      if (n_mismatch == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
